>>> sv/gle_pkg.sv
package gle_pkg;

    localparam int MAX_CODES    = 4096;
    localparam int DICT_ENTRIES = 1048576;

    localparam int CODE_W  = 12;
    localparam int NEXT_W  = 13;
    localparam int WIDTH_W = 4;
    localparam int SIZE_W  = 4;
    localparam int PIX_W   = 8;
    localparam int DICT_AW = $clog2(DICT_ENTRIES);
    localparam int SLOT_AW = $clog2(MAX_CODES);

    localparam logic [WIDTH_W-1:0] WIDTH_CAP  = 4'd12;
    localparam logic [SIZE_W-1:0]  SIZE_LO    = 4'd2;
    localparam logic [SIZE_W-1:0]  SIZE_HI    = 4'd8;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 4'd8;

    // packer holds up to 7 leftover bits plus one full-width code
    localparam int ACC_W = 19;
    localparam int CNT_W = 5;

    localparam int TOK_DEPTH = 4;
    localparam int TOK_AW    = $clog2(TOK_DEPTH);

    typedef enum logic {
        TOK_CODE,
        TOK_FLUSH
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t            kind;
        logic [CODE_W-1:0]    code;
        logic [WIDTH_W-1:0]   width;
    } token_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_READ,
        ST_CHECK,
        ST_FULL_PX,
        ST_FULL_CLR,
        ST_END_PFX,
        ST_END_CODE,
        ST_FLUSH
    } core_state_t;

    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] code,
                                                    input logic [WIDTH_W-1:0] width);
        logic [CODE_W:0] m;
        m = ({{CODE_W{1'b0}}, 1'b1} << width) - {{CODE_W{1'b0}}, 1'b1};
        return code & m[CODE_W-1:0];
    endfunction

endpackage

>>> sv/gle_core.sv
module gle_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_wdata,
    input  logic            pixel_valid,
    output logic            pixel_stall,
    input  logic [7:0]      pixel_value,
    input  logic            last_pixel,
    output logic            tok_push,
    output gle_pkg::token_t tok_data,
    input  logic            tok_full
);
    import gle_pkg::*;

    core_state_t         state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   eff_size;
    logic [8:0]          clear_code;
    logic [PIX_W-1:0]    px_mask, px_in;
    logic [CODE_W-1:0]   clear_word, end_word;
    logic [NEXT_W-1:0]   init_next;
    logic [WIDTH_W-1:0]  init_width;

    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic [NEXT_W-1:0]   next_code_reg, next_code_next;
    logic [NEXT_W-1:0]   base_reg, base_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic                take_reg, take_next;
    logic                started_reg, started_next;
    logic                last_reg, last_next;
    logic [PIX_W-1:0]    px_reg, px_next;
    logic [DICT_AW-1:0]  idx_reg, idx_next;

    // dictionary: (prefix, pixel) -> code
    logic [CODE_W-1:0]   dict_mem [DICT_ENTRIES];
    logic [CODE_W-1:0]   dict_q_reg;
    logic                byp_hit_reg, byp_hit_next;
    logic [CODE_W-1:0]   byp_data_reg;
    logic [CODE_W-1:0]   dict_word;
    logic                rd_en;
    logic                wr_en;

    // code -> slot it was written to; confirms a dictionary entry belongs to this table
    logic [DICT_AW-1:0]  slot_mem [MAX_CODES];
    logic [DICT_AW-1:0]  slot_q_reg;

    logic                take_now;
    logic                full_soon;
    logic                hit;
    logic                can_take;
    logic                accept;

    always_comb
    begin
        if (size_reg < SIZE_LO)
            eff_size = SIZE_LO;
        else if (size_reg > SIZE_HI)
            eff_size = SIZE_HI;
        else
            eff_size = size_reg;
    end

    assign clear_code = 9'd1 << eff_size;
    assign px_mask    = PIX_W'(clear_code - 9'd1);
    assign px_in      = pixel_value & px_mask;
    assign clear_word = {3'b000, clear_code};
    assign end_word   = clear_word + {{(CODE_W-1){1'b0}}, 1'b1};
    assign init_next  = {4'b0000, clear_code} + NEXT_W'(2);
    assign init_width = eff_size + 4'd1;

    assign take_now  = take_reg || !started_reg;
    assign full_soon = next_code_reg >= NEXT_W'(MAX_CODES - 1);
    assign dict_word = byp_hit_reg ? byp_data_reg : dict_q_reg;
    assign hit       = ({1'b0, dict_word} >= base_reg) && ({1'b0, dict_word} < next_code_reg)
                       && (slot_q_reg == idx_reg);
    assign accept    = pixel_valid && can_take;
    assign pixel_stall = !can_take;

    always_comb
    begin
        state_next     = state_reg;
        size_next      = cfg_we ? cfg_wdata : size_reg;
        prefix_next    = prefix_reg;
        next_code_next = next_code_reg;
        base_next      = base_reg;
        width_next     = width_reg;
        take_next      = take_reg;
        started_next   = started_reg;
        last_next      = last_reg;
        px_next        = px_reg;
        idx_next       = idx_reg;
        tok_push       = 1'b0;
        tok_data.kind  = TOK_CODE;
        tok_data.code  = mask_code(prefix_reg, width_reg);
        tok_data.width = width_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        can_take       = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                can_take = !tok_full;
                if (accept)
                begin
                    px_next   = px_in;
                    last_next = last_pixel;
                    if (!started_reg)
                    begin
                        tok_push       = 1'b1;
                        tok_data.code  = mask_code(clear_word, init_width);
                        tok_data.width = init_width;
                        next_code_next = init_next;
                        base_next      = init_next;
                        width_next     = init_width;
                        started_next   = 1'b1;
                    end
                    if (take_now)
                    begin
                        prefix_next = {4'b0000, px_in};
                        take_next   = 1'b0;
                        state_next  = last_pixel ? ST_END_PFX : ST_RUN;
                    end
                    else
                    begin
                        idx_next   = DICT_AW'({prefix_reg, px_in});
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                can_take = !tok_full && !last_reg && !full_soon;
                if (hit)
                begin
                    prefix_next = dict_word;
                    if (last_reg)
                        state_next = ST_END_PFX;
                    else if (accept)
                    begin
                        px_next    = px_in;
                        last_next  = last_pixel;
                        idx_next   = DICT_AW'({dict_word, px_in});
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                        state_next = ST_RUN;
                end
                else if (!tok_full)
                begin
                    // string ends: send prefix, add the new entry
                    tok_push       = 1'b1;
                    wr_en          = 1'b1;
                    next_code_next = next_code_reg + NEXT_W'(1);
                    if (width_reg < WIDTH_CAP && next_code_reg == (NEXT_W'(1) << width_reg))
                        width_next = width_reg + 4'd1;
                    prefix_next = {4'b0000, px_reg};
                    if (full_soon)
                        state_next = ST_FULL_PX;
                    else if (last_reg)
                        state_next = ST_END_PFX;
                    else if (accept)
                    begin
                        px_next    = px_in;
                        last_next  = last_pixel;
                        idx_next   = DICT_AW'({{4'b0000, px_reg}, px_in});
                        rd_en      = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                        state_next = ST_RUN;
                end
            end

            ST_FULL_PX:
            begin
                tok_data.code = mask_code({4'b0000, px_reg}, width_reg);
                if (!tok_full)
                begin
                    tok_push   = 1'b1;
                    state_next = ST_FULL_CLR;
                end
            end

            ST_FULL_CLR:
            begin
                tok_data.code = mask_code(clear_word, width_reg);
                if (!tok_full)
                begin
                    tok_push       = 1'b1;
                    next_code_next = init_next;
                    base_next      = init_next;
                    width_next     = init_width;
                    take_next      = 1'b1;
                    state_next     = last_reg ? ST_END_CODE : ST_RUN;
                end
            end

            ST_END_PFX:
            begin
                if (!tok_full)
                begin
                    tok_push   = 1'b1;
                    state_next = ST_END_CODE;
                end
            end

            ST_END_CODE:
            begin
                tok_data.code = mask_code(end_word, width_reg);
                if (!tok_full)
                begin
                    tok_push   = 1'b1;
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                tok_data.kind = TOK_FLUSH;
                if (!tok_full)
                begin
                    tok_push     = 1'b1;
                    prefix_next  = '0;
                    take_next    = 1'b1;
                    started_next = 1'b0;
                    state_next   = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // a read issued while the previous item writes the same slot takes the new word
    assign byp_hit_next = wr_en && (idx_reg == idx_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            size_reg      <= SIZE_RESET;
            prefix_reg    <= '0;
            next_code_reg <= NEXT_W'(258);
            base_reg      <= NEXT_W'(258);
            width_reg     <= 4'd9;
            take_reg      <= 1'b1;
            started_reg   <= 1'b0;
            last_reg      <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            prefix_reg    <= prefix_next;
            next_code_reg <= next_code_next;
            base_reg      <= base_next;
            width_reg     <= width_next;
            take_reg      <= take_next;
            started_reg   <= started_next;
            last_reg      <= last_next;
            if (rd_en)
                byp_hit_reg <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        idx_reg <= idx_next;
        if (rd_en)
            byp_data_reg <= next_code_reg[CODE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            dict_q_reg <= dict_mem[idx_next];
        if (wr_en)
            dict_mem[idx_reg] <= next_code_reg[CODE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            slot_q_reg <= slot_mem[dict_word[SLOT_AW-1:0]];
        if (wr_en)
            slot_mem[next_code_reg[SLOT_AW-1:0]] <= idx_reg;
    end

endmodule

>>> sv/gle_tok_fifo.sv
module gle_tok_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gle_pkg::token_t push_data,
    output logic            full,
    input  logic            pop,
    output gle_pkg::token_t pop_data,
    output logic            not_empty
);
    import gle_pkg::*;

    token_t              mem [TOK_DEPTH];
    logic [TOK_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [TOK_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [TOK_AW:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = count_reg == (TOK_AW+1)'(TOK_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == TOK_AW'(TOK_DEPTH - 1)) ? '0 : wr_ptr_reg + TOK_AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == TOK_AW'(TOK_DEPTH - 1)) ? '0 : rd_ptr_reg + TOK_AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (TOK_AW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (TOK_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

>>> sv/gle_packer.sv
module gle_packer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    input  gle_pkg::token_t tok_data,
    output logic            tok_pop,
    output logic            byte_valid,
    input  logic            byte_stall,
    output logic [7:0]      out_byte,
    output logic            last_byte
);
    import gle_pkg::*;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic [7:0]        byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [ACC_W-1:0]  acc_load;
    logic [CNT_W-1:0]  cnt_load;
    logic              slot_free;
    logic              emit;

    assign slot_free = !valid_reg || !byte_stall;
    assign acc_load  = acc_reg | (ACC_W'(tok_data.code) << cnt_reg[2:0]);
    assign cnt_load  = cnt_reg + CNT_W'(tok_data.width);

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        tok_pop   = 1'b0;
        emit      = 1'b0;

        if (cnt_reg >= CNT_W'(8))
        begin
            if (slot_free)
            begin
                emit      = 1'b1;
                byte_next = acc_reg[7:0];
                last_next = 1'b0;
                acc_next  = acc_reg >> 8;
                cnt_next  = cnt_reg - CNT_W'(8);
            end
        end
        else if (tok_valid)
        begin
            if (tok_data.kind == TOK_CODE)
            begin
                tok_pop = 1'b1;
                if (cnt_load >= CNT_W'(8) && slot_free)
                begin
                    emit      = 1'b1;
                    byte_next = acc_load[7:0];
                    last_next = 1'b0;
                    acc_next  = acc_load >> 8;
                    cnt_next  = cnt_load - CNT_W'(8);
                end
                else
                begin
                    acc_next = acc_load;
                    cnt_next = cnt_load;
                end
            end
            else if (slot_free)
            begin
                // end of image: leftover bits go out as the final item, even when none
                tok_pop   = 1'b1;
                emit      = 1'b1;
                byte_next = acc_reg[7:0];
                last_next = 1'b1;
                acc_next  = '0;
                cnt_next  = '0;
            end
        end

        if (emit)
            valid_next = 1'b1;
        else if (!byte_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign byte_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign last_byte  = last_reg;

endmodule

>>> sv/gif_lzw_encoder_unit.sv
// Path: a pixel that ends a string is decided in ST_CHECK, after ST_READ; its code's
//   bytes then reach the output register through the token FIFO and the packer.
// Pace: set by the dictionary read, code-slot check and write loop (no pixel is taken in
//   ST_READ); an image's first pixel needs no read, a full table and the image end add states.
// Reset: asynchronous, active low; control state and min_code_size (8) clear at once. The
//   dictionary needs no clearing pass: each entry is confirmed against a code-to-slot table.
module gif_lzw_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  pixel_value,
    input  logic        last_pixel,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte
);
    import gle_pkg::*;

    token_t push_tok;
    token_t pop_tok;
    logic   tok_push;
    logic   tok_full;
    logic   tok_pop;
    logic   tok_valid;

    gle_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_value (pixel_value),
        .last_pixel  (last_pixel),
        .tok_push    (tok_push),
        .tok_data    (push_tok),
        .tok_full    (tok_full)
    );

    gle_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tok_push),
        .push_data (push_tok),
        .full      (tok_full),
        .pop       (tok_pop),
        .pop_data  (pop_tok),
        .not_empty (tok_valid)
    );

    gle_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (tok_valid),
        .tok_data   (pop_tok),
        .tok_pop    (tok_pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

endmodule

>>> sv/gle_checker.sv
module gle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic       last_pixel,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic [7:0] out_byte,
    input logic       last_byte
);

    // images taken whose final item has not yet gone out
    logic [3:0] open_reg;
    logic       img_in;
    logic       img_out;

    assign img_in  = pixel_valid && !pixel_stall && last_pixel;
    assign img_out = byte_valid && !byte_stall && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else if (img_in && !img_out)
            open_reg <= open_reg + 4'd1;
        else if (img_out && !img_in)
            open_reg <= open_reg - 4'd1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(out_byte) && $stable(last_byte))
        else $error("output item changed while stalled");

    // checked at the next edge: the output register may be unknown before reset first acts
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !byte_valid)
        else $error("output valid during reset");

    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        img_in |=> pixel_stall)
        else $error("pixel taken right after an image end");

    a_last_follows_image: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && last_byte |-> open_reg != 4'd0)
        else $error("final item without an image end");

endmodule

bind gif_lzw_encoder_unit gle_checker u_checker (.*);
